// ----- rtl/rmtc_pkg.sv -----
// Package for the radio mode controller: codes, register indexes and the
// structs passed between its modules. Depends on nothing.
`default_nettype none

package rmtc_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_RETRY_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WDOG_LIMIT       = 2'd2;

	localparam logic [7:0]  RST_SOFT_RETRY_LIMIT = 8'd2;
	localparam logic        RST_WATCHDOG_ENABLE  = 1'b0;
	localparam logic [31:0] RST_WDOG_LIMIT       = 32'd400000;

	// Item kinds.
	localparam logic OP_POLL = 1'b0;
	localparam logic OP_IRQ  = 1'b1;

	// Interrupt causes.
	localparam logic [2:0] CAUSE_RX_START = 3'd0;
	localparam logic [2:0] CAUSE_RX_OK    = 3'd1;
	localparam logic [2:0] CAUSE_TX_OK    = 3'd2;
	localparam logic [2:0] CAUSE_TX_FAIL  = 3'd3;
	localparam logic [2:0] CAUSE_HW_FAIL  = 3'd4;

	// Mode change commands.
	localparam logic [1:0] GO_NONE = 2'd0;
	localparam logic [1:0] GO_TX   = 2'd1;
	localparam logic [1:0] GO_RX   = 2'd2;
	localparam logic [1:0] GO_IDLE = 2'd3;

	// Radio mode codes as shown on the result channel.
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_RX_IDLE = 3'd1;
	localparam logic [2:0] MODE_RX_BUSY = 3'd2;
	localparam logic [2:0] MODE_TX_IDLE = 3'd3;
	localparam logic [2:0] MODE_TX_BUSY = 3'd4;

	typedef struct packed {
		logic [7:0]  soft_retry_limit;
		logic        watchdog_enable;
		logic [31:0] wdog_limit;
	} cfg_t;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  intr_cause;
		logic        tx_pending;
		logic        rx_space_ok;
		logic [31:0] now_time;
	} item_t;

	typedef struct packed {
		logic       do_trx_reset;
		logic [1:0] go_mode;
		logic       start_transmit;
		logic [7:0] frame_sequence;
		logic       pop_tx_packet;
		logic       read_rx_frame;
		logic [2:0] radio_mode;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/rmtc_if.sv -----
// Valid/ready channel interfaces for the radio mode controller: one for
// the incoming poll and interrupt requests, one for the command results.
`default_nettype none

interface rmtc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  intr_cause;
	logic        tx_pending;
	logic        rx_space_ok;
	logic [31:0] now_time;

	modport source (output valid, opcode, intr_cause, tx_pending, rx_space_ok, now_time,
		input ready);
	modport sink (input valid, opcode, intr_cause, tx_pending, rx_space_ok, now_time,
		output ready);
endinterface

interface rmtc_out_if;
	logic       valid;
	logic       ready;
	logic       do_trx_reset;
	logic [1:0] go_mode;
	logic       start_transmit;
	logic [7:0] frame_sequence;
	logic       pop_tx_packet;
	logic       read_rx_frame;
	logic [2:0] radio_mode;

	modport source (output valid, do_trx_reset, go_mode, start_transmit, frame_sequence,
		pop_tx_packet, read_rx_frame, radio_mode, input ready);
	modport sink (input valid, do_trx_reset, go_mode, start_transmit, frame_sequence,
		pop_tx_packet, read_rx_frame, radio_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/radio_mac_tx_rx_controller_unit.sv -----
// Top level of the radio mode controller: request register, result register
// and the handshakes around them. Depends on rmtc_pkg, rmtc_if, rmtc_cfg, rmtc_core.
//
//   Channel  Direction  Handshake    Contents
//   item     in         valid/ready  opcode, intr_cause, tx_pending, rx_space_ok, now_time
//   result   out        valid/ready  do_trx_reset .. radio_mode, one per request
//   cfg      in         write only   cfg_we, cfg_idx, cfg_wdata
//
// A request is registered on acceptance and its result is registered when the
// request register moves on; one request is taken every cycle while the result
// is not stalled. The state advances when the request register moves into the result
// register. A stalled result holds; the request register still fills behind it.
// Reset puts the radio in rx idle with all counters and the progress time at 0.
`default_nettype none

module radio_mac_tx_rx_controller_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rmtc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rmtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rmtc_in_if.sink                             item,
	rmtc_out_if.source                          result
);

	rmtc_pkg::cfg_t    cfg;
	rmtc_pkg::item_t   item_s1;
	rmtc_pkg::result_t res_comb;
	rmtc_pkg::result_t res_s2;
	logic              item_vld_s1;
	logic              res_vld_s2;
	logic              advance;
	logic              in_fire;

	assign advance    = item_vld_s1 && (!res_vld_s2 || result.ready);
	assign item.ready = !item_vld_s1 || advance;
	assign in_fire    = item.valid && item.ready;

	rmtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rmtc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (advance),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_vld_s2  <= 1'b0;
		end else begin
			if (in_fire)
				item_vld_s1 <= 1'b1;
			else if (advance)
				item_vld_s1 <= 1'b0;
			if (advance)
				res_vld_s2 <= 1'b1;
			else if (result.ready)
				res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.opcode      <= item.opcode;
			item_s1.intr_cause  <= item.intr_cause;
			item_s1.tx_pending  <= item.tx_pending;
			item_s1.rx_space_ok <= item.rx_space_ok;
			item_s1.now_time    <= item.now_time;
		end
		if (advance)
			res_s2 <= res_comb;
	end

	assign result.valid          = res_vld_s2;
	assign result.do_trx_reset   = res_s2.do_trx_reset;
	assign result.go_mode        = res_s2.go_mode;
	assign result.start_transmit = res_s2.start_transmit;
	assign result.frame_sequence = res_s2.frame_sequence;
	assign result.pop_tx_packet  = res_s2.pop_tx_packet;
	assign result.read_rx_frame  = res_s2.read_rx_frame;
	assign result.radio_mode     = res_s2.radio_mode;

endmodule

`default_nettype wire

// ----- rtl/rmtc_cfg.sv -----
// Configuration registers of the radio mode controller.
// Depends on rmtc_pkg.
`default_nettype none

module rmtc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rmtc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [rmtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output rmtc_pkg::cfg_t                      cfg
);

	rmtc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soft_retry_limit <= rmtc_pkg::RST_SOFT_RETRY_LIMIT;
			cfg_q.watchdog_enable  <= rmtc_pkg::RST_WATCHDOG_ENABLE;
			cfg_q.wdog_limit       <= rmtc_pkg::RST_WDOG_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				rmtc_pkg::REG_SOFT_RETRY_LIMIT: cfg_q.soft_retry_limit <= cfg_wdata[7:0];
				rmtc_pkg::REG_WATCHDOG_ENABLE:  cfg_q.watchdog_enable  <= cfg_wdata[0];
				rmtc_pkg::REG_WDOG_LIMIT:       cfg_q.wdog_limit       <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/rmtc_core.sv -----
// Mode state machine, retry and sequence counters and watchdog of the radio
// mode controller. Produces the result for one request. Depends on rmtc_pkg.
`default_nettype none

module rmtc_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rmtc_pkg::cfg_t   cfg,
	input  wire rmtc_pkg::item_t  item,
	input  wire logic             fire,
	output rmtc_pkg::result_t     res
);

	typedef enum logic [2:0] {
		ST_IDLE    = rmtc_pkg::MODE_IDLE,
		ST_RX_IDLE = rmtc_pkg::MODE_RX_IDLE,
		ST_RX_BUSY = rmtc_pkg::MODE_RX_BUSY,
		ST_TX_IDLE = rmtc_pkg::MODE_TX_IDLE,
		ST_TX_BUSY = rmtc_pkg::MODE_TX_BUSY
	} state_t;

	state_t      state_q, state_n;
	logic [7:0]  retry_q, retry_n, retry_inc;
	logic [7:0]  seq_q, seq_n;
	logic [31:0] progress_q, progress_n;
	logic [31:0] elapsed;
	logic        wd_expired;
	logic        busy;

	assign elapsed    = item.now_time - progress_q;
	assign wd_expired = cfg.watchdog_enable && (elapsed > cfg.wdog_limit);
	assign busy       = (state_q == ST_RX_BUSY) || (state_q == ST_TX_BUSY);
	assign retry_inc  = retry_q + 8'd1;

	always_comb begin
		state_n    = state_q;
		retry_n    = retry_q;
		seq_n      = seq_q;
		progress_n = progress_q;
		res        = '0;

		if (item.opcode == rmtc_pkg::OP_POLL) begin
			if (wd_expired) begin
				res.do_trx_reset = 1'b1;
				res.go_mode      = rmtc_pkg::GO_IDLE;
				state_n          = ST_IDLE;
				progress_n       = item.now_time;
			end else if (item.tx_pending) begin
				// The switch to transmit and the start go out in the same result.
				if (!busy) begin
					if (state_q != ST_TX_IDLE)
						res.go_mode = rmtc_pkg::GO_TX;
					progress_n         = item.now_time;
					state_n            = ST_TX_BUSY;
					res.start_transmit = 1'b1;
					res.frame_sequence = seq_q;
					seq_n              = seq_q + 8'd1;
				end
			end else if (state_q == ST_RX_IDLE) begin
				progress_n = item.now_time;
			end else if (!busy) begin
				res.go_mode = rmtc_pkg::GO_RX;
				state_n     = ST_RX_IDLE;
				progress_n  = item.now_time;
			end
		end else begin
			case (state_q)
				ST_RX_IDLE: begin
					if (item.intr_cause == rmtc_pkg::CAUSE_RX_START)
						state_n = ST_RX_BUSY;
				end
				ST_RX_BUSY: begin
					if (item.intr_cause == rmtc_pkg::CAUSE_RX_OK) begin
						res.read_rx_frame = item.rx_space_ok;
						state_n           = ST_RX_IDLE;
					end
				end
				ST_TX_BUSY: begin
					state_n = ST_TX_IDLE;
					if (item.intr_cause == rmtc_pkg::CAUSE_TX_OK) begin
						res.pop_tx_packet = 1'b1;
						res.go_mode       = rmtc_pkg::GO_RX;
						state_n           = ST_RX_IDLE;
					end else if (item.intr_cause == rmtc_pkg::CAUSE_TX_FAIL) begin
						// The counter wraps, so a limit of 255 never drops a packet.
						if (retry_inc > cfg.soft_retry_limit) begin
							retry_n           = 8'd0;
							res.pop_tx_packet = 1'b1;
							res.go_mode       = rmtc_pkg::GO_RX;
							state_n           = ST_RX_IDLE;
						end else begin
							retry_n = retry_inc;
						end
					end
				end
				default: ;
			endcase
			if (item.intr_cause == rmtc_pkg::CAUSE_HW_FAIL)
				res.do_trx_reset = 1'b1;
		end

		res.radio_mode = state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RX_IDLE;
			retry_q    <= 8'd0;
			seq_q      <= 8'd0;
			progress_q <= 32'd0;
		end else if (fire) begin
			state_q    <= state_n;
			retry_q    <= retry_n;
			seq_q      <= seq_n;
			progress_q <= progress_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rmtc_checker.sv -----
// Port-level checks on the result channel of the radio mode controller and
// the bind that attaches them to the top level. Depends on rmtc_pkg.
`default_nettype none

module rmtc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_trx_reset,
	input wire logic [1:0] res_go_mode,
	input wire logic       res_start,
	input wire logic [7:0] res_seq,
	input wire logic       res_pop,
	input wire logic [2:0] res_mode
);

	// A stalled result must not change or vanish.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_seq)
			&& $stable(res_mode) && $stable(res_go_mode))
		else $error("result changed while stalled");

	// A started frame always leaves the radio transmitting.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_start |-> res_mode == rmtc_pkg::MODE_TX_BUSY)
		else $error("transmit started outside tx busy");

	// Without a start the sequence field is zero.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_start |-> res_seq == 8'd0)
		else $error("sequence number shown without a start");

	// Dropping or finishing a packet always returns the radio to receive.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pop |-> res_go_mode == rmtc_pkg::GO_RX
			&& res_mode == rmtc_pkg::MODE_RX_IDLE)
		else $error("packet popped without a return to receive");

	// Only the watchdog commands idle, and it always resets the transceiver.
	a_wdog: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_go_mode == rmtc_pkg::GO_IDLE |-> res_trx_reset
			&& res_mode == rmtc_pkg::MODE_IDLE)
		else $error("idle command without a transceiver reset");

endmodule

bind radio_mac_tx_rx_controller_unit rmtc_checker u_rmtc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_trx_reset (result.do_trx_reset),
	.res_go_mode   (result.go_mode),
	.res_start     (result.start_transmit),
	.res_seq       (result.frame_sequence),
	.res_pop       (result.pop_tx_packet),
	.res_mode      (result.radio_mode)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for the radio mode controller: sends poll and interrupt
// requests, predicts each command result and compares it field by field.
// Depends on rmtc_pkg, rmtc_if and radio_mac_tx_rx_controller_unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmtc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	// Codes the package leaves unnamed.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [2:0] CAUSE_UNDEF_LO = 3'd5;
	localparam logic [2:0] CAUSE_UNDEF_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rmtc_in_if req_ch ();
	rmtc_out_if cmd_ch ();

	radio_mac_tx_rx_controller_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (req_ch),
		.result    (cmd_ch)
	);

	// Predicted controller state and register copies.
	logic [2:0]  radio_state;
	logic [7:0]  retry_cnt;
	logic [7:0]  seq_num;
	logic [31:0] progress_mark;
	logic [7:0]  retry_limit;
	logic        wd_enabled;
	logic [31:0] wd_timeout;

	result_t expected_cmds[$];
	int unsigned fail_count = 0;
	logic [31:0] cycle_count = '0;
	logic [31:0] clock_now = '0;
	int burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic radio_busy();
		return radio_state == MODE_RX_BUSY || radio_state == MODE_TX_BUSY;
	endfunction

	function automatic result_t predict_commands(item_t req);
		result_t r;
		logic [31:0] quiet_time;
		r = '0;
		if (req.opcode == OP_POLL) begin
			quiet_time = req.now_time - progress_mark;
			if (wd_enabled && quiet_time > wd_timeout) begin
				r.do_trx_reset = 1'b1;
				r.go_mode = GO_IDLE;
				radio_state = MODE_IDLE;
				progress_mark = req.now_time;
			end else if (req.tx_pending) begin
				if (radio_state == MODE_TX_IDLE || !radio_busy()) begin
					if (radio_state != MODE_TX_IDLE)
						r.go_mode = GO_TX;
					progress_mark = req.now_time;
					radio_state = MODE_TX_BUSY;
					r.start_transmit = 1'b1;
					r.frame_sequence = seq_num;
					seq_num = seq_num + 8'd1;
				end
			end else if (radio_state == MODE_RX_IDLE || !radio_busy()) begin
				if (radio_state != MODE_RX_IDLE)
					r.go_mode = GO_RX;
				radio_state = MODE_RX_IDLE;
				progress_mark = req.now_time;
			end
		end else begin
			case (radio_state)
				MODE_RX_IDLE: begin
					if (req.intr_cause == CAUSE_RX_START)
						radio_state = MODE_RX_BUSY;
				end
				MODE_RX_BUSY: begin
					if (req.intr_cause == CAUSE_RX_OK) begin
						r.read_rx_frame = req.rx_space_ok;
						radio_state = MODE_RX_IDLE;
					end
				end
				MODE_TX_BUSY: begin
					// Any interrupt ends the transmission; the radio then leaves tx idle
					// for receive only when the packet is gone.
					radio_state = MODE_TX_IDLE;
					if (req.intr_cause == CAUSE_TX_OK) begin
						r.pop_tx_packet = 1'b1;
						r.go_mode = GO_RX;
						radio_state = MODE_RX_IDLE;
					end else if (req.intr_cause == CAUSE_TX_FAIL) begin
						retry_cnt = retry_cnt + 8'd1;
						if (retry_cnt > retry_limit) begin
							retry_cnt = '0;
							r.pop_tx_packet = 1'b1;
							r.go_mode = GO_RX;
							radio_state = MODE_RX_IDLE;
						end
					end
				end
				default: ;
			endcase
			if (req.intr_cause == CAUSE_HW_FAIL)
				r.do_trx_reset = 1'b1;
		end
		r.radio_mode = radio_state;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		result_t want;
		item_t req;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (expected_cmds.size() == 0) begin
					fail_count++;
					$error("result arrived with no request outstanding");
				end else begin
					want = expected_cmds.pop_front();
					check_field("do_trx_reset", 32'(want.do_trx_reset),
						32'(cmd_ch.do_trx_reset));
					check_field("go_mode", 32'(want.go_mode), 32'(cmd_ch.go_mode));
					check_field("start_transmit", 32'(want.start_transmit),
						32'(cmd_ch.start_transmit));
					check_field("frame_sequence", 32'(want.frame_sequence),
						32'(cmd_ch.frame_sequence));
					check_field("pop_tx_packet", 32'(want.pop_tx_packet),
						32'(cmd_ch.pop_tx_packet));
					check_field("read_rx_frame", 32'(want.read_rx_frame),
						32'(cmd_ch.read_rx_frame));
					check_field("radio_mode", 32'(want.radio_mode), 32'(cmd_ch.radio_mode));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				req.opcode = req_ch.opcode;
				req.intr_cause = req_ch.intr_cause;
				req.tx_pending = req_ch.tx_pending;
				req.rx_space_ok = req_ch.rx_space_ok;
				req.now_time = req_ch.now_time;
				expected_cmds.push_back(predict_commands(req));
			end
		end
	end

	// The receiver picks its stall behavior from bits 9:8 of the cycle count.
	always @(posedge clk) begin
		case (cycle_count[9:8])
			2'd0: cmd_ch.ready <= 1'b1;
			2'd1: cmd_ch.ready <= 1'($urandom_range(0, 1));
			2'd2: cmd_ch.ready <= ($urandom_range(0, 3) == 0);
			default: cmd_ch.ready <= cycle_count[3];
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 32'd1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic item_t mk_req(logic op, logic [2:0] cause, logic txp, logic rxs,
			logic [31:0] t);
		item_t r;
		r.opcode = op;
		r.intr_cause = cause;
		r.tx_pending = txp;
		r.rx_space_ok = rxs;
		r.now_time = t;
		return r;
	endfunction

	// Time moves forward in small steps, with an occasional jump anywhere.
	function automatic logic [31:0] next_now(int step_max);
		if ($urandom_range(0, 49) == 0)
			clock_now = $urandom;
		else
			clock_now = clock_now + $urandom_range(0, step_max);
		return clock_now;
	endfunction

	task automatic send_req(item_t r);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opcode;
		req_ch.intr_cause <= r.intr_cause;
		req_ch.tx_pending <= r.tx_pending;
		req_ch.rx_space_ok <= r.rx_space_ok;
		req_ch.now_time <= r.now_time;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		// Wait for a clock edge first so that the last accepted request has been predicted.
		@(posedge clk);
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SOFT_RETRY_LIMIT: retry_limit = data[7:0];
			REG_WATCHDOG_ENABLE: wd_enabled = data[0];
			REG_WDOG_LIMIT: wd_timeout = data;
			default: ;
		endcase
	endtask

	task automatic run_traffic(int n, int tx_pct, int fail_pct, int noise_pct, int step_max);
		int sent;
		logic [2:0] tx_cause;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_req(mk_req(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), next_now(step_max)));
				sent += 1;
			end else if ($urandom_range(0, 99) < tx_pct) begin
				tx_cause = ($urandom_range(0, 99) < fail_pct) ? CAUSE_TX_FAIL : CAUSE_TX_OK;
				send_req(mk_req(OP_POLL, 3'($urandom_range(0, 7)), 1'b1,
					1'($urandom_range(0, 1)), next_now(step_max)));
				send_req(mk_req(OP_IRQ, tx_cause, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), next_now(step_max)));
				sent += 2;
			end else begin
				send_req(mk_req(OP_POLL, 3'($urandom_range(0, 7)), 1'b0,
					1'($urandom_range(0, 1)), next_now(step_max)));
				send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), next_now(step_max)));
				send_req(mk_req(OP_IRQ, CAUSE_RX_OK, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), next_now(step_max)));
				sent += 3;
			end
		end
	endtask

	// Receive handshake, busy refusals, the retry limit and ignored causes,
	// under the reset register values.
	task automatic test_directed();
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, 32'h0000_0000));
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b0, 1'b1, 32'h0000_0001));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, 32'h0000_0002));
		send_req(mk_req(OP_POLL, CAUSE_UNDEF_HI, 1'b0, 1'b1, 32'h0000_0003));
		send_req(mk_req(OP_IRQ, CAUSE_RX_OK, 1'b1, 1'b0, 32'h0000_0004));
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b0, 1'b0, 32'h0000_0005));
		send_req(mk_req(OP_IRQ, CAUSE_RX_OK, 1'b0, 1'b1, 32'h0000_0006));
		send_req(mk_req(OP_IRQ, CAUSE_UNDEF_LO, 1'b1, 1'b1, 32'h0000_0007));
		send_req(mk_req(OP_IRQ, CAUSE_UNDEF_HI, 1'b0, 1'b0, 32'h0000_0008));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b1, 32'hFFFF_FFFF));
		send_req(mk_req(OP_IRQ, CAUSE_HW_FAIL, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b1, 1'b0, 32'h8000_0000));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, 32'h5555_5555));
		send_req(mk_req(OP_IRQ, CAUSE_TX_FAIL, 1'b0, 1'b0, 32'hAAAA_AAAA));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, 32'h0000_0100));
		send_req(mk_req(OP_IRQ, CAUSE_TX_FAIL, 1'b1, 1'b1, 32'h0000_0101));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, 32'h0000_0102));
		send_req(mk_req(OP_IRQ, CAUSE_TX_FAIL, 1'b0, 1'b1, 32'h0000_0103));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, 32'h0000_0104));
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b1, 1'b0, 32'h0000_0105));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, 32'h0000_0106));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b1, 32'h0000_0107));
		send_req(mk_req(OP_IRQ, CAUSE_TX_OK, 1'b0, 1'b0, 32'h0000_0108));
		send_req(mk_req(OP_IRQ, CAUSE_HW_FAIL, 1'b0, 1'b1, 32'h0000_0109));
		send_req(mk_req(OP_POLL, CAUSE_HW_FAIL, 1'b0, 1'b1, 32'h0000_010A));
		clock_now = 32'h0000_0200;
	endtask

	task automatic test_defaults();
		run_traffic(150, 50, 50, 25, 40);
	endtask

	// Limit of zero drops a packet on its first failure; the watchdog is on
	// with the largest timeout, so it can never expire.
	task automatic test_retry_zero();
		wait_idle();
		cfg_write(REG_SOFT_RETRY_LIMIT, 32'h0000_0000);
		cfg_write(REG_WDOG_LIMIT, 32'hFFFF_FFFF);
		cfg_write(REG_WATCHDOG_ENABLE, 32'h0000_0001);
		run_traffic(80, 70, 50, 20, 40);
	endtask

	task automatic test_watchdog();
		logic [31:0] t0;
		wait_idle();
		cfg_write(REG_WDOG_LIMIT, 32'd100);
		cfg_write(REG_WATCHDOG_ENABLE, 32'h0000_0001);
		t0 = progress_mark + 32'd1000;
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0));
		// Only a hardware failure acts while the radio is idle.
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b0, 1'b0, t0));
		send_req(mk_req(OP_IRQ, CAUSE_HW_FAIL, 1'b0, 1'b0, t0));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd100));
		send_req(mk_req(OP_IRQ, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd120));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, t0 + 32'd150));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, t0 + 32'd201));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b1, 1'b0, t0 + 32'd201));
		wait_idle();
		cfg_write(REG_WDOG_LIMIT, 32'd0);
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd201));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd202));
		wait_idle();
		cfg_write(REG_WDOG_LIMIT, 32'hFFFF_FFFF);
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd201));
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd200));
		wait_idle();
		// Only bit 0 of the enable register counts.
		cfg_write(REG_WATCHDOG_ENABLE, 32'hFFFF_FFFE);
		send_req(mk_req(OP_POLL, CAUSE_RX_START, 1'b0, 1'b0, t0 + 32'd1000000));
		clock_now = t0 + 32'd1000000;
	endtask

	// With a limit of 255 the retry counter wraps instead of dropping, and the
	// traffic is almost all failed transmissions.
	task automatic test_retry_wrap();
		wait_idle();
		cfg_write(REG_SOFT_RETRY_LIMIT, 32'hABCD_12FF);
		cfg_write(REG_UNUSED, $urandom);
		run_traffic(560, 100, 97, 0, 40);
	endtask

	task automatic test_mixed_config();
		wait_idle();
		cfg_write(REG_SOFT_RETRY_LIMIT, {24'($urandom_range(0, 32'hFF_FFFF)),
			8'($urandom_range(1, 254))});
		cfg_write(REG_WATCHDOG_ENABLE, {31'($urandom), 1'b1});
		cfg_write(REG_WDOG_LIMIT, $urandom_range(50, 600));
		run_traffic(150, 50, 40, 25, 60);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_SOFT_RETRY_LIMIT;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_POLL;
		req_ch.intr_cause <= CAUSE_RX_START;
		req_ch.tx_pending <= 1'b0;
		req_ch.rx_space_ok <= 1'b0;
		req_ch.now_time <= '0;
		radio_state = MODE_RX_IDLE;
		retry_cnt = '0;
		seq_num = '0;
		progress_mark = '0;
		retry_limit = RST_SOFT_RETRY_LIMIT;
		wd_enabled = RST_WATCHDOG_ENABLE;
		wd_timeout = RST_WDOG_LIMIT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_defaults();
		test_retry_zero();
		test_watchdog();
		test_retry_wrap();
		test_mixed_config();

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
